FILE: rtl/core/bda_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the width constants, the digit type and the cell control struct.
// It depends on nothing and every other file uses it.
package bda_pkg;

    // Width of the value field on the input channel.
    localparam int VALUE_W = 64;
    // Number of low value bits that take part in the conversion (8 to 64).
    localparam int VALUE_BITS = 64;
    // Decimal digits needed for 2^VALUE_BITS - 1; log10(2) is about 0.30103.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int CHAR_W = 6;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [3:0] digit_t;

    // Operation applied to every cell of the chain in one cycle.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/bda_in_if.sv
// Input channel of the converter: one unsigned binary value per transfer.
// Depends on bda_pkg for the field width.
interface bda_in_if;
    logic                        valid;
    logic                        ready;
    logic [bda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/core/bda_out_if.sv
// Output channel of the converter: one ASCII digit per transfer.
// Depends on bda_pkg for the character width.
interface bda_out_if;
    logic                       valid;
    logic                       ready;
    logic [bda_pkg::CHAR_W-1:0] digit_char;
    logic                       last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink (input valid, input digit_char, input last, output ready);
endinterface

FILE: rtl/core/bda_cell.sv
// One BCD digit cell of the double dabble chain.
// Depends on bda_pkg for the digit type and the control struct.
module bda_cell (
    input  logic                clk,
    input  bda_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    input  bda_pkg::digit_t     digit_in,
    output bda_pkg::digit_t     digit,
    output logic                carry_out
);
    import bda_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adjusted;

    // Add three before the shift so the doubled digit carries at ten.
    assign adjusted  = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adjusted[3];
    assign digit     = digit_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

FILE: rtl/core/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level: control and chain of BCD cells.
// Steps: the value is shifted in bit-serially through double dabble, then up to NUM_DIGITS - 1
// leading zeros are dropped, then the digits are sent one per cycle while chars.ready stays high.
// A new value is taken only in idle, after the last digit of the previous one has been sent.
// Reset (rst_n low) returns to idle.
module binary_to_decimal_ascii (
    input logic      clk,
    input logic      rst_n,
    bda_in_if.sink   numbers,
    bda_out_if.source chars
);
    import bda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]  remain_reg, remain_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    cell_ctrl_t ctrl;
    digit_t     digits [NUM_DIGITS];
    logic       carry  [NUM_DIGITS+1];
    digit_t     top_digit;
    logic       in_xfer, out_xfer;

    assign in_xfer   = numbers.valid && numbers.ready;
    assign out_xfer  = chars.valid && chars.ready;
    assign top_digit = digits[NUM_DIGITS-1];

    assign numbers.ready    = (state_reg == ST_IDLE);
    assign chars.valid      = (state_reg == ST_EMIT);
    assign chars.digit_char = ASCII_ZERO + CHAR_W'(top_digit);
    assign chars.last       = (remain_reg == DIG_CNT_W'(1));

    assign carry[0] = value_reg[VALUE_BITS-1];

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cells
        bda_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .digit_in  ((i == 0) ? 4'd0 : digits[(i == 0) ? 0 : i-1]),
            .digit     (digits[i]),
            .carry_out (carry[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        bit_cnt_next = bit_cnt_reg;
        remain_next = remain_reg;
        value_next  = value_reg;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ctrl.clear   = 1'b1;
                    value_next   = numbers.value[VALUE_BITS-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                value_next   = {value_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    remain_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros but always keep the units digit.
                if (top_digit == 4'd0 && remain_reg != DIG_CNT_W'(1))
                begin
                    ctrl.shift  = 1'b1;
                    remain_next = remain_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    ctrl.shift  = 1'b1;
                    remain_next = remain_reg - DIG_CNT_W'(1);
                    if (remain_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // The top cell never overflows: the chain is wide enough for any value.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> !carry[NUM_DIGITS])
        else $error("digit chain overflow during conversion");

    // Every emitted character is a decimal digit.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid |-> (top_digit <= 4'd9))
        else $error("non-decimal digit on output");

    // The converter never takes a new value while digits are still pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(numbers.ready && chars.valid))
        else $error("input ready while output pending");

    // A transfer marked last returns the block to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && chars.last) |=> numbers.ready)
        else $error("block not idle after last digit");

endmodule
